FILE: sv/dtrl_pkg.sv
// Package: shared types, widths and constants for the dual torque ramp limiter.
package dtrl_pkg;

    // Fixed-point scaling
    localparam int FULL_SCALE     = 16384;
    localparam int RAMP_FRAC_BITS = 7;
    localparam int GAIN_SHIFT     = 14;

    // Field widths
    localparam int REQ_W  = 16;
    localparam int RATE_W = 16;
    localparam int LIM_W  = 15;
    localparam int TRQ_W  = 16;

    // Ramp accumulator and its update arithmetic
    localparam int ACC_W     = REQ_W + RAMP_FRAC_BITS;
    localparam int RAMP_AR_W = ((ACC_W > RATE_W) ? ACC_W : RATE_W) + 2;

    // Sum / clamp arithmetic width (two targets plus limit headroom)
    localparam int SUM_W = TRQ_W + 2;

    // Product width of torque times gain
    localparam int PROD_W = 2 * TRQ_W;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16384);

    typedef enum logic [2:0] {
        REG_DRIVE_BUILD   = 3'd0,
        REG_DRIVE_RELEASE = 3'd1,
        REG_BRAKE_BUILD   = 3'd2,
        REG_BRAKE_RELEASE = 3'd3,
        REG_DRIVE_LIMIT   = 3'd4,
        REG_REGEN_LIMIT   = 3'd5,
        REG_CURRENT_GAIN  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [RATE_W-1:0] drive_build_rate;
        logic [RATE_W-1:0] drive_release_rate;
        logic [RATE_W-1:0] brake_build_rate;
        logic [RATE_W-1:0] brake_release_rate;
        logic [LIM_W-1:0]  drive_limit;
        logic [LIM_W-1:0]  regen_limit;
        logic [LIM_W-1:0]  current_gain;
    } cfg_t;

endpackage

FILE: sv/dtrl_regs.sv
// Configuration register file behind the APB-style port.
module dtrl_regs
    import dtrl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_DRIVE_BUILD:   cfg_next.drive_build_rate   = pwdata[RATE_W-1:0];
                REG_DRIVE_RELEASE: cfg_next.drive_release_rate = pwdata[RATE_W-1:0];
                REG_BRAKE_BUILD:   cfg_next.brake_build_rate   = pwdata[RATE_W-1:0];
                REG_BRAKE_RELEASE: cfg_next.brake_release_rate = pwdata[RATE_W-1:0];
                REG_DRIVE_LIMIT:   cfg_next.drive_limit        = pwdata[LIM_W-1:0];
                REG_REGEN_LIMIT:   cfg_next.regen_limit        = pwdata[LIM_W-1:0];
                REG_CURRENT_GAIN:  cfg_next.current_gain       = pwdata[LIM_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drive_build_rate   <= '0;
            cfg_reg.drive_release_rate <= '0;
            cfg_reg.brake_build_rate   <= '0;
            cfg_reg.brake_release_rate <= '0;
            cfg_reg.drive_limit        <= LIMIT_RESET;
            cfg_reg.regen_limit        <= LIMIT_RESET;
            cfg_reg.current_gain       <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_DRIVE_BUILD:   prdata = DATA_W'(cfg_reg.drive_build_rate);
            REG_DRIVE_RELEASE: prdata = DATA_W'(cfg_reg.drive_release_rate);
            REG_BRAKE_BUILD:   prdata = DATA_W'(cfg_reg.brake_build_rate);
            REG_BRAKE_RELEASE: prdata = DATA_W'(cfg_reg.brake_release_rate);
            REG_DRIVE_LIMIT:   prdata = DATA_W'(cfg_reg.drive_limit);
            REG_REGEN_LIMIT:   prdata = DATA_W'(cfg_reg.regen_limit);
            REG_CURRENT_GAIN:  prdata = DATA_W'(cfg_reg.current_gain);
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: sv/dtrl_ramp.sv
// One slew-limited ramp channel: accumulator register and its step logic.
module dtrl_ramp
    import dtrl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    upd,
    input  logic signed [REQ_W-1:0] req,
    input  logic        [RATE_W-1:0] build_rate,
    input  logic        [RATE_W-1:0] release_rate,
    input  logic                    build_ok,
    output logic signed [TRQ_W-1:0] target
);

    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     goal;
    logic        [RATE_W-1:0]    step;
    logic signed [RAMP_AR_W-1:0] acc_x;
    logic signed [RAMP_AR_W-1:0] goal_x;
    logic signed [RAMP_AR_W-1:0] step_x;
    logic signed [RAMP_AR_W-1:0] up;
    logic signed [RAMP_AR_W-1:0] dn;
    logic                        req_nz;

    // Goal and step selection; build step gated by enable/start
    always_comb begin
        req_nz = (req != '0);
        goal   = req_nz ? ACC_W'(req) <<< RAMP_FRAC_BITS : '0;
        if (req_nz) begin
            step = build_ok ? build_rate : '0;
        end else begin
            step = release_rate;
        end
    end

    // Step toward the goal without passing it
    always_comb begin
        acc_x  = RAMP_AR_W'(acc_reg);
        goal_x = RAMP_AR_W'(goal);
        step_x = RAMP_AR_W'($signed({1'b0, step}));
        up     = acc_x + step_x;
        dn     = acc_x - step_x;
        if (acc_x < goal_x) begin
            acc_next = (up > goal_x) ? goal : up[ACC_W-1:0];
        end else if (acc_x > goal_x) begin
            acc_next = (dn < goal_x) ? goal : dn[ACC_W-1:0];
        end else begin
            acc_next = acc_reg;
        end
    end

    // Floor shift of the new accumulator value
    assign target = acc_next[ACC_W-1:RAMP_FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (upd) begin
            acc_reg <= acc_next;
        end
    end

endmodule

FILE: sv/dtrl_limit.sv
// Torque sum, full-scale clamp, direction limits and current gain scaling.
module dtrl_limit
    import dtrl_pkg::*;
(
    input  logic signed [TRQ_W-1:0] drive_target,
    input  logic signed [TRQ_W-1:0] brake_target,
    input  logic                    reverse_mode,
    input  cfg_t                    cfg,
    output logic signed [TRQ_W-1:0] current_command
);

    localparam logic signed [SUM_W-1:0] FS_POS = SUM_W'(FULL_SCALE);
    localparam logic signed [SUM_W-1:0] FS_NEG = -FS_POS;

    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  clamped;
    logic signed [SUM_W-1:0]  hi_lim;
    logic signed [SUM_W-1:0]  lo_lim;
    logic signed [SUM_W-1:0]  limited;
    logic signed [TRQ_W-1:0]  torque;
    logic signed [PROD_W-1:0] prod;

    // Sum and clamp to full scale
    always_comb begin
        sum = SUM_W'(drive_target) + SUM_W'(brake_target);
        if (sum > FS_POS) begin
            clamped = FS_POS;
        end else if (sum < FS_NEG) begin
            clamped = FS_NEG;
        end else begin
            clamped = sum;
        end
    end

    // Direction limits: upper bound tested first
    always_comb begin
        if (reverse_mode) begin
            hi_lim = $signed(SUM_W'(cfg.regen_limit));
            lo_lim = -$signed(SUM_W'(cfg.drive_limit));
        end else begin
            hi_lim = $signed(SUM_W'(cfg.drive_limit));
            lo_lim = -$signed(SUM_W'(cfg.regen_limit));
        end
        if (clamped > hi_lim) begin
            limited = hi_lim;
        end else if (clamped < lo_lim) begin
            limited = lo_lim;
        end else begin
            limited = clamped;
        end
    end

    // Gain scaling, floor shift, wrap to 16 bits
    assign torque          = limited[TRQ_W-1:0];
    assign prod            = torque * $signed({1'b0, cfg.current_gain});
    assign current_command = prod[GAIN_SHIFT+TRQ_W-1:GAIN_SHIFT];

endmodule

FILE: sv/dual_torque_ramp_limiter_core.sv
// Top level: input register, ramp/limit datapath, enable logic, result register.
//
// Usage:
//   Input transactions (s_valid/s_ready) carry one control tick: drive and
//   brake torque requests, direction, start permission and global enable.
//   Each accepted transaction yields exactly one result transaction
//   (m_valid/m_ready) with both ramp targets, the current command and the
//   motor enable, PWM arm and start-consumed flags.
//   An accepted transaction is held in the input register, then passes through
//   the ramp, limit and gain logic into the result register, where the ramp
//   accumulators and enable bit also update and m_valid is raised.
//   Throughput is one transaction per cycle while the receiver does not
//   stall, since the accumulators and enable bit update with each result.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more transaction; s_ready drops only when
//   both are full and m_ready is low.
//   Reset clears the accumulators, the enable bit and both valid flags,
//   and returns the configuration registers to their reset values.
//   Configuration goes through the APB-style port at byte address 4*index.
module dual_torque_ramp_limiter_core
    import dtrl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    // Input channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [REQ_W-1:0] s_drive_request,
    input  logic signed [REQ_W-1:0] s_brake_request,
    input  logic                    s_reverse_mode,
    input  logic                    s_start_allowed,
    input  logic                    s_global_enable,
    // Result channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [TRQ_W-1:0] m_drive_target,
    output logic signed [TRQ_W-1:0] m_brake_target,
    output logic signed [TRQ_W-1:0] m_current_command,
    output logic                    m_motor_enabled,
    output logic                    m_pwm_arm,
    output logic                    m_start_consumed
);

    cfg_t cfg;

    // Input register
    logic                    in_vld_reg;
    logic                    in_vld_next;
    logic signed [REQ_W-1:0] dreq_reg;
    logic signed [REQ_W-1:0] breq_reg;
    logic                    rev_reg;
    logic                    start_reg;
    logic                    gen_reg;

    // Result register
    logic                    out_vld_reg;
    logic                    out_vld_next;
    logic signed [TRQ_W-1:0] dtgt_reg;
    logic signed [TRQ_W-1:0] btgt_reg;
    logic signed [TRQ_W-1:0] cmd_reg;
    logic                    men_reg;
    logic                    arm_reg;
    logic                    consumed_reg;

    // Enable state
    logic                    en_reg;
    logic                    en_next;

    logic                    advance;
    logic                    fire;
    logic                    build_ok;
    logic signed [TRQ_W-1:0] dtgt;
    logic signed [TRQ_W-1:0] btgt;
    logic signed [TRQ_W-1:0] cmd;
    logic                    want;
    logic                    arm_next;
    logic                    consumed_next;

    dtrl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline handshake
    assign advance = !out_vld_reg || m_ready;
    assign fire    = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;
    assign build_ok = en_reg || start_reg;

    dtrl_ramp u_drive_ramp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .upd          (fire),
        .req          (dreq_reg),
        .build_rate   (cfg.drive_build_rate),
        .release_rate (cfg.drive_release_rate),
        .build_ok     (build_ok),
        .target       (dtgt)
    );

    dtrl_ramp u_brake_ramp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .upd          (fire),
        .req          (breq_reg),
        .build_rate   (cfg.brake_build_rate),
        .release_rate (cfg.brake_release_rate),
        .build_ok     (build_ok),
        .target       (btgt)
    );

    dtrl_limit u_limit (
        .drive_target    (dtgt),
        .brake_target    (btgt),
        .reverse_mode    (rev_reg),
        .cfg             (cfg),
        .current_command (cmd)
    );

    // Motor enable, PWM arm and start consumption
    always_comb begin
        want = gen_reg && (cmd != '0 || breq_reg != '0 || dreq_reg != '0 ||
                           dtgt != '0 || btgt != '0);
        arm_next      = 1'b0;
        consumed_next = 1'b0;
        en_next       = en_reg;
        if (want) begin
            arm_next = !en_reg;
            if (start_reg) begin
                en_next       = 1'b1;
                consumed_next = 1'b1;
            end
        end else if (cmd == '0 && dtgt == '0 && btgt == '0) begin
            en_next = 1'b0;
        end
    end

    // Valid flags
    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (fire) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            en_reg      <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (fire) begin
                en_reg <= en_next;
            end
        end
    end

    // Input payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            dreq_reg  <= s_drive_request;
            breq_reg  <= s_brake_request;
            rev_reg   <= s_reverse_mode;
            start_reg <= s_start_allowed;
            gen_reg   <= s_global_enable;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            dtgt_reg     <= dtgt;
            btgt_reg     <= btgt;
            cmd_reg      <= cmd;
            men_reg      <= en_next;
            arm_reg      <= arm_next;
            consumed_reg <= consumed_next;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_drive_target    = dtgt_reg;
    assign m_brake_target    = btgt_reg;
    assign m_current_command = cmd_reg;
    assign m_motor_enabled   = men_reg;
    assign m_pwm_arm         = arm_reg;
    assign m_start_consumed  = consumed_reg;

`ifndef SYNTH
    // A consumed start always leaves the motor enabled
    a_consumed_enables: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_start_consumed |-> m_motor_enabled)
        else $error("start consumed without motor enable");

    // Enable state changes only when a transaction is processed
    a_en_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(en_reg))
        else $error("enable bit changed without a transaction");

    // Backpressure only when both stages are full and the receiver stalls
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // Result register reflects the enable bit just written
    a_men_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (m_motor_enabled == en_reg))
        else $error("reported motor enable differs from state");
`endif

endmodule

FILE: dv/dual_torque_ramp_limiter_core_tb.sv
// Testbench for the dual torque ramp limiter core: random ticks checked against a predictor.
`timescale 1ns / 100ps

module dual_torque_ramp_limiter_core_tb;
    import dtrl_pkg::*;

    // Mismatch lines shown before reporting goes quiet
    localparam int SHOW_LIMIT = 40;
    // Register slot with no register behind it
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_PHASES = 10;
    localparam int TICKS_PER_PHASE = 170;

    typedef struct packed {
        logic signed [REQ_W-1:0] drive_request;
        logic signed [REQ_W-1:0] brake_request;
        logic                    reverse_mode;
        logic                    start_allowed;
        logic                    global_enable;
    } tick_t;

    typedef struct packed {
        logic signed [TRQ_W-1:0] drive_target;
        logic signed [TRQ_W-1:0] brake_target;
        logic signed [TRQ_W-1:0] current_command;
        logic                    motor_enabled;
        logic                    pwm_arm;
        logic                    start_consumed;
    } torque_result_t;

    // Torque predictor plus the queue of results still owed by the block
    class torque_scoreboard;
        cfg_t           regs;
        longint         drive_acc;
        longint         brake_acc;
        bit             motor_on;
        torque_result_t owed_q[$];
        int             errors;
        int             checked;
        int             n_ticks;
        int             n_clamped;
        int             n_limited;
        int             n_consumed;
        int             n_armed;

        function new();
            regs = '0;
            regs.drive_limit = LIMIT_RESET;
            regs.regen_limit = LIMIT_RESET;
            drive_acc = 0;
            brake_acc = 0;
            motor_on = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_DRIVE_BUILD:   regs.drive_build_rate   = value[RATE_W-1:0];
                REG_DRIVE_RELEASE: regs.drive_release_rate = value[RATE_W-1:0];
                REG_BRAKE_BUILD:   regs.brake_build_rate   = value[RATE_W-1:0];
                REG_BRAKE_RELEASE: regs.brake_release_rate = value[RATE_W-1:0];
                REG_DRIVE_LIMIT:   regs.drive_limit        = value[LIM_W-1:0];
                REG_REGEN_LIMIT:   regs.regen_limit        = value[LIM_W-1:0];
                REG_CURRENT_GAIN:  regs.current_gain       = value[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        // One slew step of a Q7 accumulator; returns the floored target
        function longint slew(inout longint acc, input longint req,
                              input longint bld, input longint rls);
            longint goal;
            longint step;
            goal = (req != 0) ? (req <<< RAMP_FRAC_BITS) : 64'sd0;
            step = (req != 0) ? bld : rls;
            if (acc < goal) begin
                acc += step;
                if (acc > goal) acc = goal;
            end else if (acc > goal) begin
                acc -= step;
                if (acc < goal) acc = goal;
            end
            return acc >>> RAMP_FRAC_BITS;
        endfunction

        // Accepted input transaction: advance the state, queue the result
        function void note_input(tick_t t);
            longint         dreq, breq, dtgt, btgt, total, hi, lo, gain, bld_d, bld_b;
            logic signed [TRQ_W-1:0] cmd;
            bit             want, arm, used;
            torque_result_t r;
            dreq = longint'($signed(t.drive_request));
            breq = longint'($signed(t.brake_request));
            // build rates only act once the motor is on or a start is allowed
            if (motor_on || t.start_allowed) begin
                bld_d = longint'(regs.drive_build_rate);
                bld_b = longint'(regs.brake_build_rate);
            end else begin
                bld_d = 0;
                bld_b = 0;
            end
            dtgt = slew(drive_acc, dreq, bld_d, longint'(regs.drive_release_rate));
            btgt = slew(brake_acc, breq, bld_b, longint'(regs.brake_release_rate));

            // full-scale clamp on the unwrapped sum
            total = dtgt + btgt;
            if (total > FULL_SCALE) begin
                total = FULL_SCALE;
                n_clamped++;
            end else if (total < -FULL_SCALE) begin
                total = -FULL_SCALE;
                n_clamped++;
            end

            // direction limits, upper bound first
            hi = longint'(t.reverse_mode ? regs.regen_limit : regs.drive_limit);
            lo = longint'(t.reverse_mode ? regs.drive_limit : regs.regen_limit);
            if (total > hi) begin
                total = hi;
                n_limited++;
            end else if (total < -lo) begin
                total = -lo;
                n_limited++;
            end

            gain = longint'(regs.current_gain);
            cmd = TRQ_W'((total * gain) >>> GAIN_SHIFT);

            // motor enable bookkeeping
            want = (cmd != 0 || breq != 0 || dreq != 0 || dtgt != 0 || btgt != 0)
                   && t.global_enable;
            arm = 1'b0;
            used = 1'b0;
            if (want) begin
                arm = !motor_on;
                if (t.start_allowed) begin
                    motor_on = 1'b1;
                    used = 1'b1;
                end
            end else if (cmd == 0 && dtgt == 0 && btgt == 0) begin
                motor_on = 1'b0;
            end

            r.drive_target    = TRQ_W'(dtgt);
            r.brake_target    = TRQ_W'(btgt);
            r.current_command = cmd;
            r.motor_enabled   = motor_on;
            r.pwm_arm         = arm;
            r.start_consumed  = used;
            owed_q.push_back(r);
            n_ticks++;
            if (arm) n_armed++;
            if (used) n_consumed++;
        endfunction

        function void flag(string field, longint want_v, longint got_v);
            if (want_v != got_v) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
                else if (errors == SHOW_LIMIT + 1)
                    $display("further mismatches are counted but not shown");
            end
        endfunction

        // Accepted result transaction: compare with the oldest owed result
        function void check_result(torque_result_t got);
            torque_result_t due;
            if (owed_q.size() == 0) begin
                errors++;
                $error("result transaction with no tick outstanding");
                return;
            end
            due = owed_q.pop_front();
            checked++;
            flag("drive_target", $signed(due.drive_target), $signed(got.drive_target));
            flag("brake_target", $signed(due.brake_target), $signed(got.brake_target));
            flag("current_command", $signed(due.current_command),
                 $signed(got.current_command));
            flag("motor_enabled", due.motor_enabled, got.motor_enabled);
            flag("pwm_arm", due.pwm_arm, got.pwm_arm);
            flag("start_consumed", due.start_consumed, got.start_consumed);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [REQ_W-1:0] s_drive_request;
    logic signed [REQ_W-1:0] s_brake_request;
    logic                    s_reverse_mode;
    logic                    s_start_allowed;
    logic                    s_global_enable;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [TRQ_W-1:0] m_drive_target;
    logic signed [TRQ_W-1:0] m_brake_target;
    logic signed [TRQ_W-1:0] m_current_command;
    logic                    m_motor_enabled;
    logic                    m_pwm_arm;
    logic                    m_start_consumed;

    torque_scoreboard sb = new();
    bit src_idle_on;
    bit sink_stall_on;
    int settings_used;

    dual_torque_ramp_limiter_core u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit, well above the slowest legal run
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Observe both channels; inputs are noted before results are checked
    always @(posedge aclk) begin : monitor
        tick_t          t;
        torque_result_t r;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                t.drive_request = s_drive_request;
                t.brake_request = s_brake_request;
                t.reverse_mode  = s_reverse_mode;
                t.start_allowed = s_start_allowed;
                t.global_enable = s_global_enable;
                sb.note_input(t);
            end
            if (m_valid && m_ready) begin
                r.drive_target    = m_drive_target;
                r.brake_target    = m_brake_target;
                r.current_command = m_current_command;
                r.motor_enabled   = m_motor_enabled;
                r.pwm_arm         = m_pwm_arm;
                r.start_consumed  = m_start_consumed;
                sb.check_result(r);
            end
        end
    end

    // Receiver: runs of ready, short stalls and the odd long one
    initial begin : sink_ctrl
        int pick;
        int span;
        forever begin
            pick = $urandom_range(0, 99);
            if (!sink_stall_on || pick < 55) begin
                m_ready <= 1'b1;
                span = $urandom_range(1, 8);
            end else if (pick < 95) begin
                m_ready <= 1'b0;
                span = $urandom_range(1, 3);
            end else begin
                m_ready <= 1'b0;
                span = $urandom_range(4, 100);
            end
            repeat (span) @(posedge aclk);
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (!src_idle_on || pick < 60) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 50);
    endfunction

    function automatic logic [REQ_W-1:0] pick_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) return '0;
        if (pick < 35) return ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
        if (pick < 45) return REQ_W'($urandom());
        return REQ_W'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return RATE_W'($urandom_range(16384, 65535));
        if (pick < 70) return RATE_W'($urandom_range(1, 4096));
        return RATE_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return LIM_W'($urandom_range(0, 32767));
        if (pick < 45) return LIMIT_RESET;
        return LIM_W'($urandom_range(0, 16384));
    endfunction

    // One input transaction, with an optional gap in front
    task automatic tick(input logic [REQ_W-1:0] dreq, input logic [REQ_W-1:0] breq,
                        input bit rev, input bit start, input bit gen);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_drive_request <= dreq;
        s_brake_request <= breq;
        s_reverse_mode  <= rev;
        s_start_allowed <= start;
        s_global_enable <= gen;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Unused upper data bits carry noise; the registers keep their low bits
    task automatic program_config(input cfg_t c);
        apb_write(REG_DRIVE_BUILD,   {16'($urandom()), c.drive_build_rate});
        apb_write(REG_DRIVE_RELEASE, {16'($urandom()), c.drive_release_rate});
        apb_write(REG_BRAKE_BUILD,   {16'($urandom()), c.brake_build_rate});
        apb_write(REG_BRAKE_RELEASE, {16'($urandom()), c.brake_release_rate});
        apb_write(REG_DRIVE_LIMIT,   {17'($urandom()), c.drive_limit});
        apb_write(REG_REGEN_LIMIT,   {17'($urandom()), c.regen_limit});
        apb_write(REG_CURRENT_GAIN,  {17'($urandom()), c.current_gain});
        settings_used++;
    endtask

    // Drain every owed result, then let the pipeline go quiet
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly held requests so the ramps travel far; some pure noise
    task automatic run_sequence(output int n);
        logic [REQ_W-1:0] dreq;
        logic [REQ_W-1:0] breq;
        bit               rev;
        bit               gen;
        bit               start;
        int               k;
        if ($urandom_range(0, 3) != 0) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 24);
            dreq = pick_request();
            breq = pick_request();
            rev  = 1'($urandom_range(0, 1));
            gen  = ($urandom_range(0, 9) != 0);
            for (k = 0; k < n; k++) begin
                start = (k == 0) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 4) == 0);
                tick(dreq, breq, rev, start, gen ^ ($urandom_range(0, 19) == 0));
            end
        end else begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
                tick(REQ_W'($urandom()), REQ_W'($urandom()), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        cfg_t c;
        int   phase;
        int   sent;
        int   n;
        aresetn         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        s_valid         <= 1'b0;
        s_drive_request <= '0;
        s_brake_request <= '0;
        s_reverse_mode  <= 1'b0;
        s_start_allowed <= 1'b0;
        s_global_enable <= 1'b0;
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        settings_used = 1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: build rates are zero, so only the enable logic moves
        tick(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        tick(16'h4000, 16'h0000, 1'b0, 1'b0, 1'b1);  // arm without start
        tick(16'hC000, 16'h4000, 1'b1, 1'b1, 1'b1);  // start used, nothing ramps
        tick(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);  // idle clears the enable
        settle();

        // Fastest ramps, tight limits; unknown slot written too
        c.drive_build_rate   = 16'hFFFF;
        c.drive_release_rate = 16'hFFFF;
        c.brake_build_rate   = 16'hFFFF;
        c.brake_release_rate = 16'hFFFF;
        c.drive_limit        = LIM_W'(300);
        c.regen_limit        = LIM_W'(200);
        c.current_gain       = LIM_W'(16384);
        program_config(c);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        tick(16'h4000, 16'h0000, 1'b0, 1'b1, 1'b1);  // build on start permission
        tick(16'h4000, 16'h0000, 1'b0, 1'b0, 1'b1);  // build on motor enable
        tick(16'h4000, 16'h0000, 1'b0, 1'b0, 1'b1);
        tick(16'h4000, 16'hC000, 1'b0, 1'b0, 1'b1);
        tick(16'h7FFF, 16'h8000, 1'b0, 1'b0, 1'b1);  // field extremes
        tick(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1);
        tick(16'hC000, 16'h0000, 1'b1, 1'b0, 1'b1);  // reverse limits
        tick(16'hC000, 16'h0000, 1'b0, 1'b0, 1'b1);  // forward regen limit
        tick(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1);  // release toward zero
        tick(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        tick(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        tick(16'h0005, 16'hFFFB, 1'b0, 1'b1, 1'b0);  // requests with output disabled
        tick(16'h0005, 16'hFFFB, 1'b0, 1'b0, 1'b1);
        tick(16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1);
        tick(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);

        // Random phases, each under its own register setting
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case (phase)
                0: begin  // everything at its top
                    c.drive_build_rate   = 16'hFFFF;
                    c.drive_release_rate = 16'hFFFF;
                    c.brake_build_rate   = 16'hFFFF;
                    c.brake_release_rate = 16'hFFFF;
                    c.drive_limit        = LIM_W'(32767);
                    c.regen_limit        = LIM_W'(32767);
                    c.current_gain       = LIM_W'(32767);
                end
                1: begin  // frozen ramps, zero limits and gain
                    c = '0;
                end
                2: begin  // crawling ramps, unity gain
                    c.drive_build_rate   = 16'd1;
                    c.drive_release_rate = 16'd1;
                    c.brake_build_rate   = 16'd1;
                    c.brake_release_rate = 16'd1;
                    c.drive_limit        = LIMIT_RESET;
                    c.regen_limit        = LIMIT_RESET;
                    c.current_gain       = LIM_W'(16384);
                end
                default: begin
                    c.drive_build_rate   = pick_rate();
                    c.drive_release_rate = pick_rate();
                    c.brake_build_rate   = pick_rate();
                    c.brake_release_rate = pick_rate();
                    c.drive_limit        = pick_limit();
                    c.regen_limit        = pick_limit();
                    c.current_gain       = ($urandom_range(0, 3) == 0) ? LIM_W'(16384)
                                                                       : LIM_W'($urandom());
                end
            endcase
            program_config(c);
            src_idle_on   = ($urandom_range(0, 3) != 0);
            sink_stall_on = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < TICKS_PER_PHASE) begin
                run_sequence(n);
                sent += n;
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        $display("Ran %0d ticks under %0d register settings, %0d results checked",
                 sb.n_ticks, settings_used, sb.checked);
        $display("Full-scale clamps %0d, direction limits %0d, starts used %0d, arms %0d",
                 sb.n_clamped, sb.n_limited, sb.n_consumed, sb.n_armed);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/dtrl_pkg.sv
sv/dtrl_regs.sv
sv/dtrl_ramp.sv
sv/dtrl_limit.sv
sv/dual_torque_ramp_limiter_core.sv
dv/dual_torque_ramp_limiter_core_tb.sv
